[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the downlink frame checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off while in reset
`define DFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("downlink frame checker: assertion failed");

// Same-cycle implication
`define DFC_ASSERT_IMP(lbl, ante, cons) \
  `DFC_ASSERT(lbl, (ante) |-> (cons))

// Next-cycle implication
`define DFC_ASSERT_NXT(lbl, ante, cons) \
  `DFC_ASSERT(lbl, (ante) |=> (cons))

`endif

[rtl/dfc_pkg.sv]
// Package for the downlink frame checker: field widths, CRC constants,
// configuration register codes and the structs passed between modules.
// No dependencies.
package dfc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned FlagsW   = 16;
  localparam int unsigned CrcW     = 16;
  localparam int unsigned CountW   = 3;
  localparam int unsigned CfgIdxW  = 8;

  localparam logic [CrcW-1:0]   CrcPoly  = 16'h1021;
  localparam logic [CrcW-1:0]   CrcInit  = 16'hFFFF;
  localparam int unsigned       FrameLen = 6;
  localparam logic [CountW-1:0] CountMax = 3'd7;

  localparam logic [ByteW-1:0] MyNodeReset  = 8'd0;
  localparam logic [ByteW-1:0] ProtoIdReset = 8'd1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MY_NODE  = 8'd0,
    REG_PROTO_ID = 8'd1
  } cfg_reg_e;

  // Current register values
  typedef struct packed {
    logic [ByteW-1:0] my_node;
    logic [ByteW-1:0] proto_id;
  } cfg_t;

  // One result transaction
  typedef struct packed {
    logic              frame_ok;
    logic [ByteW-1:0]  node_id;
    logic [FlagsW-1:0] flags;
  } res_t;

endpackage

[rtl/dfc_intf.sv]
// Channel interfaces of the downlink frame checker: byte input, result output
// and configuration write. Depends on dfc_pkg for field widths.
interface dfc_in_if;
  import dfc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface dfc_out_if;
  import dfc_pkg::*;
  logic              valid;
  logic              ready;
  logic              frame_ok;
  logic [ByteW-1:0]  node_id;
  logic [FlagsW-1:0] flags;
  modport source (output valid, frame_ok, node_id, flags, input ready);
  modport sink   (input valid, frame_ok, node_id, flags, output ready);
endinterface

interface dfc_cfg_if;
  import dfc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/dfc_cfg_regs.sv]
// Configuration registers of the downlink frame checker (node id, protocol).
// Depends on dfc_pkg.
module dfc_cfg_regs
  import dfc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  logic [CfgIdxW-1:0] idx_i,
  input  logic [ByteW-1:0]   data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      unique case (idx_i)
        REG_MY_NODE:  cfg_d.my_node  = data_i;
        REG_PROTO_ID: cfg_d.proto_id = data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.my_node  <= MyNodeReset;
      cfg_q.proto_id <= ProtoIdReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/dfc_crc.sv]
// One-byte update of CRC-16/CCITT-FALSE, MSB first, unrolled over eight bits.
// Depends on dfc_pkg.
module dfc_crc
  import dfc_pkg::*;
(
  input  logic [CrcW-1:0]  crc_i,
  input  logic [ByteW-1:0] byte_i,
  output logic [CrcW-1:0]  crc_o
);

  logic [CrcW-1:0] c;

  // Shift the byte through the polynomial divider, one bit a step
  always_comb begin
    c = crc_i ^ {byte_i, {(CrcW-ByteW){1'b0}}};
    for (int i = 0; i < ByteW; i++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

[rtl/dfc_frame_ctrl.sv]
// Frame state of the downlink frame checker: byte count, running CRC, held
// fields, and the pass/fail check on the last byte. Depends on dfc_pkg, dfc_crc.
module dfc_frame_ctrl
  import dfc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             last_i,
  input  cfg_t             cfg_i,
  output res_t             res_o
);

  localparam logic [CountW-1:0] LastIdx = CountW'(FrameLen - 1);

  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CrcW-1:0]   crc_q, crc_d, crc_upd;
  logic              proto_q, proto_d;
  logic [ByteW-1:0]  node_q, node_d;
  logic [FlagsW-1:0] flags_q, flags_d;
  logic [ByteW-1:0]  crc_lo_q, crc_lo_d;
  logic              ok;

  dfc_crc u_crc (
    .crc_i  (crc_q),
    .byte_i (byte_i),
    .crc_o  (crc_upd)
  );

  // Pass only a six-byte frame with matching protocol, CRC and address
  assign ok = (cnt_q == LastIdx) && proto_q && (crc_q == {byte_i, crc_lo_q})
              && (node_q == cfg_i.my_node);

  assign res_o.frame_ok = ok;
  assign res_o.node_id  = ok ? node_q : '0;
  assign res_o.flags    = ok ? flags_q : '0;

  // Capture the field at the current offset, then advance or clear
  always_comb begin
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    proto_d  = proto_q;
    node_d   = node_q;
    flags_d  = flags_q;
    crc_lo_d = crc_lo_q;
    if (step_i) begin
      case (cnt_q)
        3'd0: begin
          proto_d = (byte_i == cfg_i.proto_id);
          crc_d   = crc_upd;
        end
        3'd1: begin
          node_d = byte_i;
          crc_d  = crc_upd;
        end
        3'd2: begin
          flags_d[ByteW-1:0] = byte_i;
          crc_d              = crc_upd;
        end
        3'd3: begin
          flags_d[FlagsW-1:ByteW] = byte_i;
          crc_d                   = crc_upd;
        end
        3'd4:    crc_lo_d = byte_i;
        default: ;
      endcase
      if (last_i) begin
        cnt_d    = '0;
        crc_d    = CrcInit;
        proto_d  = 1'b0;
        node_d   = '0;
        flags_d  = '0;
        crc_lo_d = '0;
      end else if (cnt_q != CountMax) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      crc_q    <= CrcInit;
      proto_q  <= 1'b0;
      node_q   <= '0;
      flags_q  <= '0;
      crc_lo_q <= '0;
    end else begin
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
      proto_q  <= proto_d;
      node_q   <= node_d;
      flags_q  <= flags_d;
      crc_lo_q <= crc_lo_d;
    end
  end

endmodule

[rtl/downlink_frame_checker_top.sv]
// Top level of the downlink frame checker: input register, frame state and
// result register. Depends on dfc_pkg, dfc_intf, dfc_cfg_regs, dfc_frame_ctrl.
//
// Usage:
//   in_i   carries one frame byte per transaction, last_byte on the final one.
//   out_o  carries one result transaction per frame (frame_ok, node_id,
//          flags), issued for the byte that has last_byte set.
//   cfg_i  writes my_node (index 0) or proto_id (index 1); always ready.
//          Write only while no frame byte is in flight.
// Throughput: one byte per cycle, sustained, unless a final byte waits on a
//   stuck result. Each byte passes an input register and is folded into the
//   frame state by one unrolled CRC step. The final byte's verdict is loaded
//   into the result register from the input register.
// Reset: frame state clears (CRC to 0xFFFF), my_node to 0, proto_id to 1,
//   both channels empty.
// Stall: a waiting result holds in the result register. Non-final bytes keep
//   flowing; a final byte waits in the input register until the result is
//   taken, and in_i.ready falls only then.
module downlink_frame_checker_top
  import dfc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  dfc_cfg_if.sink   cfg_i,
  dfc_in_if.sink    in_i,
  dfc_out_if.source out_o
);

  cfg_t             cfg;
  res_t             res;
  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             adv;
  logic             out_vld_q, out_vld_d;
  res_t             out_q;

  assign cfg_i.ready = 1'b1;

  dfc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_i.valid),
    .idx_i  (cfg_i.index),
    .data_i (cfg_i.data),
    .cfg_o  (cfg)
  );

  // Advance the held byte unless it produces a result with no room for it
  assign adv         = in_vld_q && (!in_last_q || !out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || adv;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_i.ready) begin
      in_vld_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Input payload: load on every transaction
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  dfc_frame_ctrl u_frame (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register: load on a final byte, drop once taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (adv && in_last_q) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) begin
      out_q <= res;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.frame_ok = out_q.frame_ok;
  assign out_o.node_id  = out_q.node_id;
  assign out_o.flags    = out_q.flags;

endmodule

[rtl/dfc_checker.sv]
// Port-level checker for the downlink frame checker, bound to the top level.
// Depends on dfc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dfc_checker
  import dfc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_last,
  input logic              out_valid,
  input logic              out_ready,
  input logic              frame_ok,
  input logic [ByteW-1:0]  node_id,
  input logic [FlagsW-1:0] flags
);

  // A stalled result holds its valid and payload
  `DFC_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                  out_valid && $stable(frame_ok) && $stable(node_id) && $stable(flags))

  // Input back-pressure only while a result is stuck at the output
  `DFC_ASSERT_IMP(a_in_stall, !in_ready, out_valid && !out_ready)

  // A new result follows an earlier final-byte transaction at the input
  `DFC_ASSERT_IMP(a_out_cause, $rose(out_valid),
                  $past(in_valid && in_ready && in_last, 2))

  // A failed frame carries no node or flags
  `DFC_ASSERT_IMP(a_fail_zero, out_valid && !frame_ok, node_id == '0 && flags == '0)

endmodule

bind downlink_frame_checker_top dfc_checker u_dfc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_last   (in_i.last_byte),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .frame_ok  (out_o.frame_ok),
  .node_id   (out_o.node_id),
  .flags     (out_o.flags)
);

[test/testbench.sv]
`timescale 1ns / 1ps
// Testbench for downlink_frame_checker_top: a scoreboard predicts each frame verdict
// from accepted bytes and register writes, and randomly paced tasks drive the channels.
// Depends on dfc_pkg, the dfc channel interfaces and the RTL of the top level.
module testbench;
  import dfc_pkg::*;

  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned DrainCycles    = 6;
  localparam int unsigned Phases         = 6;
  localparam int unsigned PhaseItems     = 270;
  localparam int unsigned ReportLimit    = 10;
  localparam int unsigned RegFirstUnused = int'(REG_PROTO_ID) + 1;

  // Frame verdict predictor with its own copy of registers and frame state
  class frame_scoreboard;
    logic [ByteW-1:0]  my_node;
    logic [ByteW-1:0]  proto_id;
    logic [CountW-1:0] count;
    logic [CrcW-1:0]   crc;
    logic              proto_match;
    logic [ByteW-1:0]  node_hold;
    logic [FlagsW-1:0] flags_hold;
    logic [ByteW-1:0]  crc_low;
    res_t              verdicts[$];
    int unsigned       mismatches;

    function new();
      my_node    = MyNodeReset;
      proto_id   = ProtoIdReset;
      mismatches = 0;
      clear_frame();
    endfunction

    // One MSB-first CCITT step over a byte
    static function logic [CrcW-1:0] crc_update(logic [CrcW-1:0] c, logic [ByteW-1:0] b);
      logic [CrcW-1:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) r = r[CrcW-1] ? ((r << 1) ^ CrcPoly) : (r << 1);
      return r;
    endfunction

    function void clear_frame();
      count       = '0;
      crc         = CrcInit;
      proto_match = 1'b0;
      node_hold   = '0;
      flags_hold  = '0;
      crc_low     = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
      if (idx == REG_MY_NODE) my_node = val;
      else if (idx == REG_PROTO_ID) proto_id = val;
    endfunction

    // Fold one accepted byte into the frame state; queue a verdict on the final byte
    function void note_byte(logic [ByteW-1:0] b, logic last);
      res_t v;
      logic ok;
      case (count)
        3'd0: begin
          proto_match = (b == proto_id);
          crc = crc_update(crc, b);
        end
        3'd1: begin
          node_hold = b;
          crc = crc_update(crc, b);
        end
        3'd2: begin
          flags_hold[7:0] = b;
          crc = crc_update(crc, b);
        end
        3'd3: begin
          flags_hold[15:8] = b;
          crc = crc_update(crc, b);
        end
        3'd4: crc_low = b;
        default: ;
      endcase
      if (!last) begin
        if (count != CountMax) count++;
        return;
      end
      ok = (count == CountW'(FrameLen - 1)) && proto_match && (crc == {b, crc_low})
           && (node_hold == my_node);
      v.frame_ok = ok;
      v.node_id  = ok ? node_hold : '0;
      v.flags    = ok ? flags_hold : '0;
      verdicts.push_back(v);
      clear_frame();
    endfunction

    function void check_result(logic ok, logic [ByteW-1:0] node, logic [FlagsW-1:0] flags);
      res_t want;
      if (verdicts.size() == 0) begin
        if (mismatches < ReportLimit)
          $display("unexpected result: ok=%0d node=%02h flags=%04h", ok, node, flags);
        mismatches++;
        return;
      end
      want = verdicts.pop_front();
      if (ok !== want.frame_ok || node !== want.node_id || flags !== want.flags) begin
        if (mismatches < ReportLimit)
          $display("result mismatch: expected ok=%0d node=%02h flags=%04h, got ok=%0d node=%02h flags=%04h",
                   want.frame_ok, want.node_id, want.flags, ok, node, flags);
        mismatches++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   calm;
  int unsigned cycles;
  int unsigned sent;
  logic [ByteW-1:0] frame_q[$];
  frame_scoreboard sb = new;

  dfc_cfg_if cfg_if ();
  dfc_in_if  in_if ();
  dfc_out_if out_if ();

  downlink_frame_checker_top u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stall the result channel at random, except in the calm stretch
  always @(negedge clk_i) begin
    out_if.ready = calm || ($urandom_range(99) >= 20);
  end

  // Observe every transaction on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.frame_ok, out_if.node_id, out_if.flags);
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) sb.note_byte(in_if.data_byte, in_if.last_byte);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("downlink_frame_checker_top verification failed");
      $finish;
    end
  end

  // Fill frame_q with bytes 0..3 and a matching little-endian CRC
  function automatic void build_frame(logic [ByteW-1:0] b0, logic [ByteW-1:0] b1,
                                      logic [FlagsW-1:0] flags);
    logic [CrcW-1:0] c;
    frame_q = {b0, b1, flags[7:0], flags[15:8]};
    c = CrcInit;
    foreach (frame_q[i]) c = frame_scoreboard::crc_update(c, frame_q[i]);
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endfunction

  // Send frame_q[first..stop-1], flagging the last byte of the whole frame
  task automatic send_span(int first, int stop);
    for (int i = first; i < stop; i++) begin
      @(negedge clk_i);
      while (!calm && $urandom_range(99) < 20) begin
        in_if.valid = 1'b0;
        @(negedge clk_i);
      end
      in_if.valid     = 1'b1;
      in_if.data_byte = frame_q[i];
      in_if.last_byte = (i == frame_q.size() - 1);
      do @(posedge clk_i); while (!in_if.ready);
      sent++;
    end
  endtask

  task automatic send_frame();
    send_span(0, frame_q.size());
  endtask

  // Drop valid and wait until every verdict has been returned and the pipe is empty
  task automatic settle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  initial begin
    int unsigned start;
    int unsigned kind;
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;

    rst_ni           = 1'b0;
    calm             = 1'b0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.last_byte  = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    out_if.ready     = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Good frame at reset settings, all-ones flags
    build_frame(ProtoIdReset, MyNodeReset, 16'hFFFF);
    send_frame();
    // Frame ending on its first byte
    frame_q = {8'hFF};
    send_frame();
    // Long frame: byte count reaches its maximum, length check fails
    build_frame(ProtoIdReset, MyNodeReset, 16'h0000);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    send_frame();
    // Bad CRC high byte
    build_frame(ProtoIdReset, MyNodeReset, 16'h5AA5);
    frame_q[5] ^= 8'h80;
    send_frame();
    settle();

    for (int ph = 0; ph < Phases; ph++) begin
      calm = (ph == 2);
      case (ph)
        0: begin
          write_reg(REG_MY_NODE, 8'hFF);
          write_reg(REG_PROTO_ID, 8'h00);
        end
        1: begin
          write_reg(REG_MY_NODE, 8'h00);
          write_reg(REG_PROTO_ID, 8'hFF);
        end
        default: begin
          write_reg(REG_MY_NODE, 8'($urandom));
          write_reg(REG_PROTO_ID, 8'($urandom));
        end
      endcase
      // Unmapped index must leave both registers alone
      write_reg(CfgIdxW'($urandom_range(255, RegFirstUnused)), 8'($urandom));

      // Register change inside a frame, with the pipe drained
      if (ph % 2 == 1) begin
        // proto_id counts only when byte 0 arrives
        build_frame(sb.proto_id, sb.my_node, 16'($urandom));
        send_span(0, 1);
        settle();
        write_reg(REG_PROTO_ID, sb.proto_id ^ 8'($urandom_range(255, 1)));
        send_span(1, frame_q.size());
      end else begin
        // my_node counts only on the final byte
        build_frame(sb.proto_id, 8'($urandom), 16'($urandom));
        send_span(0, 4);
        settle();
        write_reg(REG_MY_NODE, frame_q[1]);
        send_span(4, frame_q.size());
      end
      settle();

      // Mostly well-formed frames, the rest broken in one way each
      start = sent;
      while (sent - start < PhaseItems) begin
        kind = $urandom_range(99);
        b0 = sb.proto_id;
        b1 = sb.my_node;
        if (kind >= 60 && kind < 68) b0 ^= 8'($urandom_range(255, 1));
        if (kind >= 68 && kind < 76) b1 ^= 8'($urandom_range(255, 1));
        build_frame(b0, b1, 16'($urandom));
        if (kind >= 76 && kind < 84)
          frame_q[4 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
        else if (kind >= 84 && kind < 92)
          frame_q = frame_q[0:$urandom_range(4)];
        else if (kind >= 92 && kind < 96)
          repeat ($urandom_range(4, 1)) frame_q.push_back(8'($urandom));
        else if (kind >= 96)
          foreach (frame_q[i]) frame_q[i] = 8'($urandom);
        send_frame();
      end
      settle();
    end

    calm = 1'b0;
    if (sb.mismatches == 0) begin
      $display("downlink_frame_checker_top verification clean");
    end else begin
      $display("downlink_frame_checker_top verification failed");
    end
    $finish;
  end

endmodule
